FILE: hdl/utf8_to_ucs2_decoder_assert.svh
// Assertion macros for the UTF-8 to UCS-2 decoder checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef UTF8_TO_UCS2_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8DEC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTF8DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/utf8dec_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps

package utf8dec_pkg;

    // Lead byte class boundaries.
    localparam logic [7:0] LEAD_2B_MIN = 8'hC0;
    localparam logic [7:0] LEAD_3B_MIN = 8'hE0;
    localparam logic [7:0] LEAD_4B_MIN = 8'hF0;
    localparam logic [7:0] LEAD_5B_MIN = 8'hF8;
    localparam logic [7:0] LEAD_6B_MIN = 8'hFC;

    // Bytes still expected after each kind of lead.
    localparam logic [2:0] PEND_2B = 3'd1;
    localparam logic [2:0] PEND_3B = 3'd2;
    localparam logic [2:0] PEND_4B = 3'd3;
    localparam logic [2:0] PEND_5B = 3'd4;
    localparam logic [2:0] PEND_6B = 3'd5;

    localparam logic [15:0] CODE_INVALID = 16'hFFFF;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic        end_of_string;
        logic [15:0] code_unit;
    } out_item_t;

endpackage

FILE: hdl/utf8dec_in_stage.sv
// Input register of the decoder: holds one accepted byte until the core takes it.
// Depends on utf8dec_pkg.
`timescale 1ns / 1ps

module utf8dec_in_stage
    import utf8dec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     item_valid,
    output in_item_t item,
    input  logic     item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A new item may enter whenever the held one leaves in the same cycle.
    assign s_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_valid && s_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/utf8dec_core.sv
// Decoding step of the decoder: sequence state and the per-byte decision logic.
// Depends on utf8dec_pkg.
`timescale 1ns / 1ps

module utf8dec_core
    import utf8dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      step,
    output logic      emit,
    output out_item_t result
);

    logic [9:0]  partial_reg;
    logic [9:0]  partial_next;
    logic [2:0]  pending_reg;
    logic [2:0]  pending_next;
    logic        skip_reg;
    logic        skip_next;
    logic [2:0]  pending_dec;
    logic [15:0] value;
    logic [7:0]  b;
    logic        last;

    assign b           = item.data_byte;
    assign last        = item.last_byte;
    assign pending_dec = 3'(pending_reg - 3'd1);
    assign value       = {partial_reg, b[5:0]};

    always_comb
    begin
        partial_next         = partial_reg;
        pending_next         = pending_reg;
        skip_next            = skip_reg;
        emit                 = 1'b0;
        result.code_unit     = CODE_INVALID;
        result.end_of_string = 1'b1;

        if (pending_reg == 3'd0)
        begin
            priority if (b < LEAD_2B_MIN)
            begin
                emit                 = 1'b1;
                result.code_unit     = {8'h00, b};
                result.end_of_string = last;
            end
            else if (b < LEAD_4B_MIN)
            begin
                if (b < LEAD_3B_MIN)
                begin
                    partial_next = {5'd0, b[4:0]};
                    pending_next = PEND_2B;
                end
                else
                begin
                    partial_next = {6'd0, b[3:0]};
                    pending_next = PEND_3B;
                end
                skip_next = 1'b0;
                // A lead that is itself the last byte can never be completed.
                if (last)
                begin
                    partial_next = '0;
                    pending_next = '0;
                    emit         = 1'b1;
                end
            end
            else
            begin
                priority if (b < LEAD_5B_MIN)
                begin
                    pending_next = PEND_4B;
                end
                else if (b < LEAD_6B_MIN)
                begin
                    pending_next = PEND_5B;
                end
                else
                begin
                    pending_next = PEND_6B;
                end
                skip_next            = 1'b1;
                partial_next         = '0;
                emit                 = 1'b1;
                result.end_of_string = last;
                if (last)
                begin
                    pending_next = '0;
                    skip_next    = 1'b0;
                end
            end
        end
        else if (skip_reg)
        begin
            // The invalid marker went out with the lead, so a finished skip is silent.
            if (pending_dec == 3'd0)
            begin
                partial_next = '0;
                pending_next = '0;
                skip_next    = 1'b0;
            end
            else if (last)
            begin
                partial_next = '0;
                pending_next = '0;
                skip_next    = 1'b0;
                emit         = 1'b1;
            end
            else
            begin
                pending_next = pending_dec;
            end
        end
        else
        begin
            if (pending_dec == 3'd0)
            begin
                partial_next         = '0;
                pending_next         = '0;
                skip_next            = 1'b0;
                emit                 = 1'b1;
                result.code_unit     = value;
                result.end_of_string = last;
            end
            else if (last)
            begin
                partial_next = '0;
                pending_next = '0;
                skip_next    = 1'b0;
                emit         = 1'b1;
            end
            else
            begin
                partial_next = value[9:0];
                pending_next = pending_dec;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= '0;
            skip_reg    <= 1'b0;
        end
        else if (step)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
            skip_reg    <= skip_next;
        end
    end

endmodule

FILE: hdl/utf8dec_out_stage.sv
// Result register of the decoder: holds one code unit until the sink takes it.
// Depends on utf8dec_pkg.
`timescale 1ns / 1ps

module utf8dec_out_stage
    import utf8dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free = !valid_reg || m_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

FILE: hdl/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder.
// Depends on utf8dec_pkg, utf8dec_in_stage, utf8dec_core and utf8dec_out_stage.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: data_byte[7:0]; tlast: last_byte
//   m_axis    out        tdata: code_unit[15:0]; tlast: end_of_string
//
// One byte is accepted per cycle while s_tready is high. A result is valid on
// m_axis at the earliest once its byte has passed through the input register
// and the decoded result has been loaded into the result register.
// Bytes that produce no result never wait for the result register.
// Reset clears the sequence state and both valid flags at once.
// When the sink stalls with a result held, a byte that makes a further result
// waits in the input register and s_tready falls until the held result is taken.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder
    import utf8dec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast    // end_of_string
);

    in_item_t  s_item;
    in_item_t  item;
    logic      item_valid;
    logic      item_take;
    logic      emit;
    logic      out_free;
    out_item_t result;
    out_item_t m_item;

    assign s_item.data_byte = s_tdata;
    assign s_item.last_byte = s_tlast;

    // The held byte is decoded once its result, if any, has somewhere to go.
    assign item_take = item_valid && (!emit || out_free);

    utf8dec_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    utf8dec_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .step   (item_take),
        .emit   (emit),
        .result (result)
    );

    utf8dec_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (item_take && emit),
        .load_item (result),
        .free      (out_free),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_item    (m_item)
    );

    assign m_tdata = m_item.code_unit;
    assign m_tlast = m_item.end_of_string;

endmodule

FILE: hdl/utf8dec_checker.sv
// Port-level checker for the UTF-8 to UCS-2 decoder, bound to the top level.
// Depends on utf8_to_ucs2_decoder_assert.svh.
`timescale 1ns / 1ps
`include "utf8_to_ucs2_decoder_assert.svh"

module utf8dec_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // With the result register empty, the input side must never stall.
    `UTF8DEC_ASSERT_SAME(a_ready_when_out_empty, !m_tvalid, s_tready, "input stalled")

    // A sink that is taking results must never hold back the input side.
    `UTF8DEC_ASSERT_SAME(a_ready_when_sink_ready, m_tready, s_tready, "input held back")

    `UTF8DEC_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "result withdrawn")

    `UTF8DEC_ASSERT_NEXT(a_out_data_holds, m_tvalid && !m_tready,
        $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // An offered item carries known data.
    `UTF8DEC_ASSERT_SAME(a_in_known, s_tvalid,
        !$isunknown(s_tdata) && !$isunknown(s_tlast), "unknown input item")

endmodule

bind utf8_to_ucs2_decoder utf8dec_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
